[hw/rtl/fpfa_pkg.sv]
package fpfa_pkg;

    // Table geometry.
    localparam int SLOTS       = 64;
    localparam int AMOUNT_BITS = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int SUM_W       = AMOUNT_BITS + IDX_W;

    // Port widths fixed by the interface.
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 6;
    localparam int AMOUNT_W = 16;
    localparam int TOTAL_W  = 22;
    localparam int COUNT_W  = 32;
    localparam int MODE_W   = 2;

    localparam longint TOTAL_MAX = 64'd4194303;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

    // Placement policies.
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_NEXT  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd2;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd3;

    typedef logic [AMOUNT_BITS-1:0] amt_t;
    typedef logic [IDX_W-1:0]       idx_t;

    // One partition entry as stored in the table memory.
    typedef struct packed {
        amt_t used;
        amt_t free;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RMW   = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_ALLOC = 4'b1000
    } state_t;

    // Circular increment over the partition indexes.
    function automatic idx_t next_idx(input idx_t i);
        idx_t r;
        if (32'(i) == SLOTS - 1) begin
            r = '0;
        end else begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

endpackage

[hw/rtl/fixed_partition_fit_allocator_core.sv]
// Channel     | Ports                                                    | Handshake
// ------------+----------------------------------------------------------+-----------------------
// command     | action, slot, amount                                     | start & !busy
// result      | status, granted_slot, total_free, request_count,         | done, one cycle
//             | denied_count                                             |
// config      | cfg_wdata (fit_mode)                                     | cfg_we
//
// A load or release word reads its entry at the accepting edge and writes it back in the
// next cycle; its result strobe is registered at the write-back.
// An allocate word has the single read port walk every partition once, one entry per cycle,
// and the write-back follows.
// Per-entry valid bits make the table read as zero after reset, so no clearing pass is needed.
// The receiver cannot stall; busy drops while the strobe is shown, so a new word may follow.
module fixed_partition_fit_allocator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [fpfa_pkg::ACTION_W-1:0]   action,
    input  logic [fpfa_pkg::SLOT_W-1:0]     slot,
    input  logic [fpfa_pkg::AMOUNT_W-1:0]   amount,
    input  logic                            cfg_we,
    input  logic [fpfa_pkg::MODE_W-1:0]     cfg_wdata,
    output logic                            done,
    output logic                            status,
    output logic [fpfa_pkg::SLOT_W-1:0]     granted_slot,
    output logic [fpfa_pkg::TOTAL_W-1:0]    total_free,
    output logic [fpfa_pkg::COUNT_W-1:0]    request_count,
    output logic [fpfa_pkg::COUNT_W-1:0]    denied_count
);

    // Partition table. Each entry holds the free and used size of one partition.
    fpfa_pkg::entry_t mem [fpfa_pkg::SLOTS];
    fpfa_pkg::entry_t rdata_reg;
    logic [fpfa_pkg::SLOTS-1:0] vld_reg;
    logic                       vdat_reg;

    logic                       mem_we;
    fpfa_pkg::idx_t             waddr;
    fpfa_pkg::entry_t           wdata;
    fpfa_pkg::idx_t             raddr;

    fpfa_pkg::state_t           state_reg, state_next;
    logic [fpfa_pkg::MODE_W-1:0] mode_reg;

    // Latched command word.
    logic [fpfa_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [fpfa_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    fpfa_pkg::idx_t                idx_reg, idx_next;
    logic                          inrange_reg, inrange_next;
    fpfa_pkg::amt_t                amt_reg, amt_next;

    // Scan bookkeeping: the issue side runs one entry ahead of the data side.
    fpfa_pkg::idx_t                iss_idx_reg, iss_idx_next;
    logic [fpfa_pkg::CNT_W-1:0]    iss_cnt_reg, iss_cnt_next;
    fpfa_pkg::idx_t                dat_idx_reg, dat_idx_next;

    // Current candidate of the search.
    logic                          found_reg, found_next;
    fpfa_pkg::idx_t                best_idx_reg, best_idx_next;
    fpfa_pkg::amt_t                best_free_reg, best_free_next;

    fpfa_pkg::idx_t                rover_reg, rover_next;
    logic [fpfa_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [fpfa_pkg::COUNT_W-1:0]  req_reg, req_next;
    logic [fpfa_pkg::COUNT_W-1:0]  den_reg, den_next;

    logic                          done_reg, done_next;
    logic                          status_reg, status_next;
    logic [fpfa_pkg::SLOT_W-1:0]   gslot_reg, gslot_next;

    logic                          accept;
    logic [31:0]                   slot_wide;
    fpfa_pkg::idx_t                slot_idx;
    fpfa_pkg::entry_t              cur;
    logic                          elig;
    logic                          take;
    logic [fpfa_pkg::AMOUNT_BITS:0] rel_sum;
    fpfa_pkg::amt_t                new_free;
    logic [63:0]                   sum_wide;

    assign accept    = start && !busy;
    assign busy      = (state_reg != fpfa_pkg::ST_IDLE);
    assign slot_wide = 32'(slot);
    assign slot_idx  = slot_wide[fpfa_pkg::IDX_W-1:0];

    // An entry that was never written reads as zero.
    assign cur = vdat_reg ? rdata_reg : '0;

    assign elig = (cur.used == '0) && (cur.free >= amt_reg);

    // Whether the entry now on the read port replaces the current candidate.
    always_comb
    begin
        case (mode_reg)
            fpfa_pkg::FIT_FIRST: take = elig && !found_reg;
            fpfa_pkg::FIT_NEXT:  take = elig && !found_reg;
            fpfa_pkg::FIT_BEST:  take = elig && (!found_reg || cur.free < best_free_reg);
            fpfa_pkg::FIT_WORST: take = elig && (!found_reg || cur.free >= best_free_reg);
            default:             take = 1'b0;
        endcase
    end

    // Release folds the used size back into the free size, saturating.
    assign rel_sum = {1'b0, cur.free} + {1'b0, cur.used};

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        inrange_next   = inrange_reg;
        amt_next       = amt_reg;
        iss_idx_next   = iss_idx_reg;
        iss_cnt_next   = iss_cnt_reg;
        dat_idx_next   = dat_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_free_next = best_free_reg;
        rover_next     = rover_reg;
        sum_next       = sum_reg;
        req_next       = req_reg;
        den_next       = den_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        gslot_next     = gslot_reg;
        mem_we         = 1'b0;
        waddr          = idx_reg;
        wdata          = '0;
        raddr          = iss_idx_reg;
        new_free       = '0;

        case (state_reg)
            fpfa_pkg::ST_IDLE:
            begin
                if (action == fpfa_pkg::ACT_ALLOC)
                begin
                    raddr = (mode_reg == fpfa_pkg::FIT_NEXT) ? rover_reg : '0;
                end
                else
                begin
                    raddr = slot_idx;
                end
                if (accept)
                begin
                    act_next     = action;
                    slot_next    = slot;
                    idx_next     = slot_idx;
                    inrange_next = (slot_wide < 32'(fpfa_pkg::SLOTS));
                    amt_next     = fpfa_pkg::amt_t'(amount);
                    found_next   = 1'b0;
                    dat_idx_next = raddr;
                    iss_idx_next = fpfa_pkg::next_idx(raddr);
                    iss_cnt_next = fpfa_pkg::CNT_W'(1);
                    if (action == fpfa_pkg::ACT_ALLOC)
                    begin
                        state_next = fpfa_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = fpfa_pkg::ST_RMW;
                    end
                end
            end

            fpfa_pkg::ST_RMW:
            begin
                if (act_reg == fpfa_pkg::ACT_LOAD)
                begin
                    new_free = amt_reg;
                end
                else
                begin
                    new_free = rel_sum[fpfa_pkg::AMOUNT_BITS] ? '1
                             : rel_sum[fpfa_pkg::AMOUNT_BITS-1:0];
                end
                if (inrange_reg && (act_reg == fpfa_pkg::ACT_LOAD
                                    || act_reg == fpfa_pkg::ACT_RELEASE))
                begin
                    mem_we     = 1'b1;
                    waddr      = idx_reg;
                    wdata.free = new_free;
                    wdata.used = '0;
                    sum_next   = sum_reg - fpfa_pkg::SUM_W'(cur.free)
                               + fpfa_pkg::SUM_W'(new_free);
                end
                status_next = 1'b0;
                gslot_next  = slot_reg;
                done_next   = 1'b1;
                state_next  = fpfa_pkg::ST_IDLE;
            end

            fpfa_pkg::ST_SCAN:
            begin
                if (take)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = dat_idx_reg;
                    best_free_next = cur.free;
                end
                if (iss_cnt_reg == fpfa_pkg::CNT_W'(fpfa_pkg::SLOTS))
                begin
                    state_next = fpfa_pkg::ST_ALLOC;
                end
                else
                begin
                    raddr        = iss_idx_reg;
                    dat_idx_next = iss_idx_reg;
                    iss_idx_next = fpfa_pkg::next_idx(iss_idx_reg);
                    iss_cnt_next = iss_cnt_reg + fpfa_pkg::CNT_W'(1);
                end
            end

            fpfa_pkg::ST_ALLOC:
            begin
                if (req_reg != '1)
                begin
                    req_next = req_reg + fpfa_pkg::COUNT_W'(1);
                end
                if (found_reg)
                begin
                    mem_we      = 1'b1;
                    waddr       = best_idx_reg;
                    wdata.free  = best_free_reg - amt_reg;
                    wdata.used  = amt_reg;
                    sum_next    = sum_reg - fpfa_pkg::SUM_W'(amt_reg);
                    status_next = 1'b0;
                    gslot_next  = fpfa_pkg::SLOT_W'(best_idx_reg);
                    if (mode_reg == fpfa_pkg::FIT_NEXT)
                    begin
                        rover_next = fpfa_pkg::next_idx(best_idx_reg);
                    end
                end
                else
                begin
                    if (den_reg != '1)
                    begin
                        den_next = den_reg + fpfa_pkg::COUNT_W'(1);
                    end
                    status_next = 1'b1;
                    gslot_next  = '0;
                end
                done_next  = 1'b1;
                state_next = fpfa_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = fpfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            vdat_reg      <= 1'b0;
            state_reg     <= fpfa_pkg::ST_IDLE;
            mode_reg      <= fpfa_pkg::FIT_FIRST;
            act_reg       <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            inrange_reg   <= 1'b0;
            amt_reg       <= '0;
            iss_idx_reg   <= '0;
            iss_cnt_reg   <= '0;
            dat_idx_reg   <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_free_reg <= '0;
            rover_reg     <= '0;
            sum_reg       <= '0;
            req_reg       <= '0;
            den_reg       <= '0;
            done_reg      <= 1'b0;
            status_reg    <= 1'b0;
            gslot_reg     <= '0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            vdat_reg      <= vld_reg[raddr];
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            state_reg     <= state_next;
            act_reg       <= act_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            inrange_reg   <= inrange_next;
            amt_reg       <= amt_next;
            iss_idx_reg   <= iss_idx_next;
            iss_cnt_reg   <= iss_cnt_next;
            dat_idx_reg   <= dat_idx_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_free_reg <= best_free_next;
            rover_reg     <= rover_next;
            sum_reg       <= sum_next;
            req_reg       <= req_next;
            den_reg       <= den_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            gslot_reg     <= gslot_next;
        end
    end

    // The running sum is exact; the reported total saturates at the port width.
    assign sum_wide = 64'(sum_reg);

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_slot  = gslot_reg;
    assign total_free    = (sum_wide > 64'(fpfa_pkg::TOTAL_MAX))
                         ? fpfa_pkg::TOTAL_W'(fpfa_pkg::TOTAL_MAX)
                         : sum_wide[fpfa_pkg::TOTAL_W-1:0];
    assign request_count = req_reg;
    assign denied_count  = den_reg;

endmodule
